// ===== sv/edid_bp_pkg.sv =====
// ----------------------------------------------------------------------------
// edid_bp_pkg
// Shared constants, types and helpers of the EDID base block parser.
// ----------------------------------------------------------------------------
package edid_bp_pkg;

	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 8;
	localparam int POS_W      = 5;
	localparam int LEN_W      = 4;
	localparam int LETTER_W   = 7;

	localparam logic [CNT_W-1:0] BLOCK_LEN   = 8'd128;
	localparam logic [CNT_W-1:0] LAST_OFFSET = 8'd127;
	localparam logic [CNT_W-1:0] DESC_START  = 8'd54;
	localparam logic [CNT_W-1:0] DESC_END    = 8'd126;   // 108 + 18
	localparam logic [CNT_W-1:0] OFS_MAKER_HI = 8'd8;
	localparam logic [CNT_W-1:0] OFS_MAKER_LO = 8'd9;
	localparam logic [CNT_W-1:0] OFS_PROD_LO  = 8'd10;
	localparam logic [CNT_W-1:0] OFS_PROD_HI  = 8'd11;
	localparam logic [CNT_W-1:0] OFS_SER_0    = 8'd12;
	localparam logic [CNT_W-1:0] OFS_SER_1    = 8'd13;
	localparam logic [CNT_W-1:0] OFS_SER_2    = 8'd14;
	localparam logic [CNT_W-1:0] OFS_SER_3    = 8'd15;

	localparam logic [POS_W-1:0] POS_HDR_LAST = 5'd3;
	localparam logic [POS_W-1:0] POS_TEXT     = 5'd5;
	localparam logic [POS_W-1:0] POS_LAST     = 5'd17;

	localparam logic [LEN_W-1:0] NAME_CAP     = 4'd13;

	localparam logic [BYTE_W-1:0] TAG_NAME    = 8'hFC;
	localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_SP     = 8'h20;

	localparam logic [4:0]          LETTER_MAX  = 5'd26;
	localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd64;
	localparam logic [LETTER_W-1:0] LETTER_UNK  = 7'd63;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	// header fields handed from the parser to the result emitter
	typedef struct packed {
		logic                status;
		logic [LETTER_W-1:0] letter_first;
		logic [LETTER_W-1:0] letter_second;
		logic [LETTER_W-1:0] letter_third;
		logic [15:0]         product_id;
		logic [31:0]         serial_id;
		logic [LEN_W-1:0]    name_length;
	} snap_t;

	function automatic logic [LETTER_W-1:0] letter_of(input logic [4:0] code);
		logic [LETTER_W-1:0] r;
		if (code != 5'd0 && code <= LETTER_MAX) begin
			r = LETTER_BASE + {2'b00, code};
		end else begin
			r = LETTER_UNK;
		end
		return r;
	endfunction

endpackage

// ===== sv/edid_bp_parser.sv =====
// ----------------------------------------------------------------------------
// edid_bp_parser
// Input register and per-block parse state: identity words, descriptor scan,
// name capture and trim tracking. Hands a snapshot over on the final beat.
// ----------------------------------------------------------------------------
module edid_bp_parser
	import edid_bp_pkg::*;
#(
	parameter int NAME_BYTES = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_block,
	output logic              snap_valid,
	input  logic              snap_ready,
	output snap_t             snap,
	output logic [BYTE_W-1:0] snap_names [NAME_BYTES]
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eob_s1;

	logic [CNT_W-1:0]  count_q;
	logic [POS_W-1:0]  pos_q;
	logic [15:0]       maker_q;
	logic [15:0]       product_q;
	logic [31:0]       serial_q;
	logic              hdr_match_q;
	logic              name_found_q;
	logic              nul_seen_q;
	logic [LEN_W-1:0]  text_len_q;
	logic [LEN_W-1:0]  kept_len_q;
	logic [BYTE_W-1:0] store_q [NAME_BYTES];

	logic              consume;
	logic              in_accept;
	logic              take;
	logic              in_range;
	logic              scan;
	logic [POS_W-1:0]  k;
	logic              hdr_match_d;
	logic              name_found_d;
	logic              nul_seen_d;
	logic [LEN_W-1:0]  text_len_d;
	logic [LEN_W-1:0]  kept_len_d;
	logic              wr_en;

	// a final beat waits in s1 until the emitter is free
	assign in_stall   = valid_s1 && eob_s1 && !snap_ready;
	assign in_accept  = in_valid && !in_stall;
	assign consume    = valid_s1 && (!eob_s1 || snap_ready);
	assign snap_valid = valid_s1 && eob_s1;
	assign take       = consume && (count_q < BLOCK_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_block;
		end
	end

	assign in_range = (count_q >= DESC_START) && (count_q < DESC_END);
	assign scan     = in_range && !(name_found_q && !hdr_match_q);
	assign k        = pos_q - POS_TEXT;

	always_comb begin
		hdr_match_d  = hdr_match_q;
		name_found_d = name_found_q;
		nul_seen_d   = nul_seen_q;
		text_len_d   = text_len_q;
		kept_len_d   = kept_len_q;
		wr_en        = 1'b0;
		if (scan) begin
			if (pos_q <= POS_HDR_LAST) begin
				if (!name_found_q) begin
					priority if (pos_q == '0) begin
						hdr_match_d = (byte_s1 == CHAR_NUL);
					end else if (pos_q < POS_HDR_LAST) begin
						hdr_match_d = hdr_match_q && (byte_s1 == CHAR_NUL);
					end else begin
						hdr_match_d = hdr_match_q && (byte_s1 == TAG_NAME);
						if (hdr_match_d) begin
							name_found_d = 1'b1;
						end
					end
				end
			end else if (pos_q >= POS_TEXT && hdr_match_q) begin
				if (k < POS_W'(NAME_BYTES) && !nul_seen_q) begin
					if (byte_s1 == CHAR_NUL) begin
						nul_seen_d = 1'b1;
					end else if (text_len_q < NAME_CAP) begin
						wr_en      = 1'b1;
						text_len_d = text_len_q + 4'd1;
						if (byte_s1 != CHAR_LF && byte_s1 != CHAR_CR && byte_s1 != CHAR_SP) begin
							kept_len_d = text_len_d;
						end
					end
				end
				if (pos_q == POS_LAST) begin
					hdr_match_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pos_q        <= '0;
			maker_q      <= '0;
			product_q    <= '0;
			serial_q     <= '0;
			hdr_match_q  <= 1'b0;
			name_found_q <= 1'b0;
			nul_seen_q   <= 1'b0;
			text_len_q   <= '0;
			kept_len_q   <= '0;
		end else if (consume && eob_s1) begin
			// block done: clear for the next one
			count_q      <= '0;
			pos_q        <= '0;
			maker_q      <= '0;
			product_q    <= '0;
			serial_q     <= '0;
			hdr_match_q  <= 1'b0;
			name_found_q <= 1'b0;
			nul_seen_q   <= 1'b0;
			text_len_q   <= '0;
			kept_len_q   <= '0;
		end else if (take) begin
			count_q <= count_q + 8'd1;
			if (in_range) begin
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + 5'd1;
			end
			unique case (count_q)
				OFS_MAKER_HI: maker_q[15:8]    <= byte_s1;
				OFS_MAKER_LO: maker_q[7:0]     <= byte_s1;
				OFS_PROD_LO:  product_q[7:0]   <= byte_s1;
				OFS_PROD_HI:  product_q[15:8]  <= byte_s1;
				OFS_SER_0:    serial_q[7:0]    <= byte_s1;
				OFS_SER_1:    serial_q[15:8]   <= byte_s1;
				OFS_SER_2:    serial_q[23:16]  <= byte_s1;
				OFS_SER_3:    serial_q[31:24]  <= byte_s1;
				default: ;
			endcase
			hdr_match_q  <= hdr_match_d;
			name_found_q <= name_found_d;
			nul_seen_q   <= nul_seen_d;
			text_len_q   <= text_len_d;
			kept_len_q   <= kept_len_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (take && wr_en && text_len_q == LEN_W'(i)) begin
				store_q[i] <= byte_s1;
			end
		end
	end

	// the final beat of a full block lies past the descriptors, so the
	// registered state is already complete here
	always_comb begin
		snap = '0;
		if (count_q < LAST_OFFSET) begin
			snap.status = STATUS_SHORT;
		end else begin
			snap.status        = STATUS_OK;
			snap.letter_first  = letter_of(maker_q[14:10]);
			snap.letter_second = letter_of(maker_q[9:5]);
			snap.letter_third  = letter_of(maker_q[4:0]);
			snap.product_id    = product_q;
			snap.serial_id     = serial_q;
			snap.name_length   = kept_len_q;
		end
	end

	assign snap_names = store_q;

endmodule

// ===== sv/edid_bp_emit.sv =====
// ----------------------------------------------------------------------------
// edid_bp_emit
// Holds one block's snapshot and plays out the header result and the name
// characters through the output register.
// ----------------------------------------------------------------------------
module edid_bp_emit
	import edid_bp_pkg::*;
#(
	parameter int NAME_BYTES = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                snap_valid,
	output logic                snap_ready,
	input  snap_t               snap,
	input  logic [BYTE_W-1:0]   snap_names [NAME_BYTES],
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [LETTER_W-1:0] letter_first,
	output logic [LETTER_W-1:0] letter_second,
	output logic [LETTER_W-1:0] letter_third,
	output logic [15:0]         product_id,
	output logic [31:0]         serial_id,
	output logic [LEN_W-1:0]    name_length,
	output logic                is_name_char,
	output logic [BYTE_W-1:0]   name_char,
	output logic                last_of_run
);

	logic              pend_q;
	logic              hdr_sent_q;
	snap_t             hold_q;
	logic [LEN_W-1:0]  rem_q;
	logic [BYTE_W-1:0] chars_q [NAME_BYTES];
	logic              out_valid_q;

	logic              slot_free;
	logic              emit;
	logic              load;
	logic              last_beat;

	// take the next snapshot in the cycle the last result leaves
	assign snap_ready = !pend_q || (emit && last_beat);
	assign load       = snap_valid && snap_ready;
	assign slot_free  = !out_valid_q || !out_stall;
	assign emit       = pend_q && slot_free;
	assign last_beat  = hdr_sent_q ? (rem_q == 4'd1) : (hold_q.name_length == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			hdr_sent_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q     <= 1'b1;
				hdr_sent_q <= 1'b0;
			end else if (emit) begin
				hdr_sent_q <= 1'b1;
				if (last_beat) begin
					pend_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hold_q  <= snap;
			rem_q   <= snap.name_length;
			chars_q <= snap_names;
		end else if (emit && hdr_sent_q) begin
			// advance the name one character
			rem_q <= rem_q - 4'd1;
			for (int i = 0; i < NAME_BYTES - 1; i++) begin
				chars_q[i] <= chars_q[i+1];
			end
		end
		if (emit) begin
			last_of_run <= last_beat;
			if (hdr_sent_q) begin
				status        <= STATUS_OK;
				letter_first  <= '0;
				letter_second <= '0;
				letter_third  <= '0;
				product_id    <= '0;
				serial_id     <= '0;
				name_length   <= '0;
				is_name_char  <= 1'b1;
				name_char     <= chars_q[0];
			end else begin
				status        <= hold_q.status;
				letter_first  <= hold_q.letter_first;
				letter_second <= hold_q.letter_second;
				letter_third  <= hold_q.letter_third;
				product_id    <= hold_q.product_id;
				serial_id     <= hold_q.serial_id;
				name_length   <= hold_q.name_length;
				is_name_char  <= 1'b0;
				name_char     <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/edid_base_block_parser_core.sv =====
// ----------------------------------------------------------------------------
// edid_base_block_parser_core
// EDID base block identity parser: manufacturer, product, serial and name.
// ----------------------------------------------------------------------------
// Bytes of an EDID block enter one beat per cycle while in_stall is low, offset 0
// first, with end_of_block on the final byte. Each byte passes an input register and
// is parsed in that cycle; a non-final byte never waits there. On the final byte a
// snapshot moves to the result emitter, which sends a header result and then
// one result per kept name character, one per cycle while out_stall is low, through
// the output register, so a block yields 1 to NAME_BYTES+1 results. The next block's
// bytes stream in meanwhile; only its final byte waits in the input register
// until the emitter hands its last result to the output register, and it
// moves on in that same cycle. A block shorter than 128 bytes gives one result
// with status set; bytes past offset 127 are ignored.
// ----------------------------------------------------------------------------
module edid_base_block_parser_core
	import edid_bp_pkg::*;
#(
	parameter int NAME_BYTES = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                end_of_block,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [LETTER_W-1:0] letter_first,
	output logic [LETTER_W-1:0] letter_second,
	output logic [LETTER_W-1:0] letter_third,
	output logic [15:0]         product_id,
	output logic [31:0]         serial_id,
	output logic [LEN_W-1:0]    name_length,
	output logic                is_name_char,
	output logic [BYTE_W-1:0]   name_char,
	output logic                last_of_run
);

	logic              snap_valid;
	logic              snap_ready;
	snap_t             snap;
	logic [BYTE_W-1:0] snap_names [NAME_BYTES];

	edid_bp_parser #(
		.NAME_BYTES(NAME_BYTES)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_block (end_of_block),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap),
		.snap_names   (snap_names)
	);

	edid_bp_emit #(
		.NAME_BYTES(NAME_BYTES)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap_ready    (snap_ready),
		.snap          (snap),
		.snap_names    (snap_names),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.letter_first  (letter_first),
		.letter_second (letter_second),
		.letter_third  (letter_third),
		.product_id    (product_id),
		.serial_id     (serial_id),
		.name_length   (name_length),
		.is_name_char  (is_name_char),
		.name_char     (name_char),
		.last_of_run   (last_of_run)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the EDID base block identity parser.
// ----------------------------------------------------------------------------
// Streams short blocks and an over-long full block into the parser. The full
// block carries random identity bytes and display descriptors that are
// monitor names, near misses of the name header, other descriptor tags or noise.
// Both channels idle in random bursts until the last few blocks. A scoreboard
// predicts the header and name-character results of every block and checks
// each result beat, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	import edid_bp_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 4;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int TARGET_BYTES   = 210;
	localparam int CALM_BYTES     = 40;
	localparam int EDID_BYTES     = 128;
	localparam int DESC_FIRST     = 54;
	localparam int DESC_STRIDE    = 18;
	localparam int DESC_SLOTS     = 4;
	localparam int TEXT_START     = 5;
	localparam int TEXT_BYTES     = 13;
	localparam int TAIL_MAX       = 12;
	localparam int BURST_MAX      = 12;

	typedef enum int {DESC_NAME, DESC_NEAR_MISS, DESC_OTHER_TAG, DESC_NOISE} desc_kind_e;
	typedef enum int {TAIL_NUL, TAIL_LF_PAD, TAIL_TRIM_MIX} tail_kind_e;

	typedef struct packed {
		logic                status;
		logic [LETTER_W-1:0] letter_first;
		logic [LETTER_W-1:0] letter_second;
		logic [LETTER_W-1:0] letter_third;
		logic [15:0]         product_id;
		logic [31:0]         serial_id;
		logic [LEN_W-1:0]    name_length;
		logic                is_name_char;
		logic [BYTE_W-1:0]   name_char;
		logic                last_of_run;
	} edid_result_t;

	class edid_scoreboard;
		int                offset;
		logic [15:0]       maker;
		logic [15:0]       product;
		logic [31:0]       serial;
		bit                in_name_desc;
		bit                name_seen;
		logic [BYTE_W-1:0] text [TEXT_BYTES];
		int                text_len;
		bit                nul_hit;
		int                kept_len;
		edid_result_t      pending [$];
		int                errors = 0;
		int                bytes_in = 0;
		int                results_due = 0;
		int                results_ok = 0;
		int                full_blocks = 0;
		int                short_blocks = 0;
		int                named_blocks = 0;

		function new();
			clear_block();
		endfunction

		function void clear_block();
			offset = 0;
			maker = '0;
			product = '0;
			serial = '0;
			in_name_desc = 0;
			name_seen = 0;
			text_len = 0;
			nul_hit = 0;
			kept_len = 0;
		endfunction

		function logic [LETTER_W-1:0] maker_letter(logic [4:0] code);
			if (code >= 5'd1 && code <= 5'd26) begin
				return LETTER_BASE + {2'b00, code};
			end
			return LETTER_UNK;
		endfunction

		function void absorb(int off, logic [BYTE_W-1:0] b);
			int pos;
			case (off)
				8: maker[15:8] = b;
				9: maker[7:0] = b;
				10: product[7:0] = b;
				11: product[15:8] = b;
				12, 13, 14, 15: serial[(off - 12) * 8 +: 8] = b;
				default: ;
			endcase
			if (off < DESC_FIRST || off >= DESC_FIRST + DESC_SLOTS * DESC_STRIDE) return;
			// once a name is found, only the rest of its own descriptor matters
			if (name_seen && !in_name_desc) return;
			pos = (off - DESC_FIRST) % DESC_STRIDE;
			if (pos <= 3) begin
				if (pos == 0) begin
					in_name_desc = (b == CHAR_NUL);
				end else if (pos < 3) begin
					in_name_desc = in_name_desc && (b == CHAR_NUL);
				end else begin
					in_name_desc = in_name_desc && (b == TAG_NAME);
					if (in_name_desc) name_seen = 1;
				end
			end else if (pos >= TEXT_START && in_name_desc) begin
				if (!nul_hit) begin
					if (b == CHAR_NUL) begin
						nul_hit = 1;
					end else if (text_len < TEXT_BYTES) begin
						text[text_len] = b;
						text_len++;
						if (b != CHAR_LF && b != CHAR_CR && b != CHAR_SP) kept_len = text_len;
					end
				end
				if (pos == DESC_STRIDE - 1) in_name_desc = 0;
			end
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b, logic eob);
			edid_result_t r;
			int i;
			bytes_in++;
			if (offset < EDID_BYTES) begin
				absorb(offset, b);
				offset++;
			end
			if (!eob) return;
			r = '0;
			if (offset < EDID_BYTES) begin
				r.status = STATUS_SHORT;
				r.last_of_run = 1'b1;
				pending.push_back(r);
				short_blocks++;
				results_due++;
			end else begin
				r.status = STATUS_OK;
				r.letter_first = maker_letter(maker[14:10]);
				r.letter_second = maker_letter(maker[9:5]);
				r.letter_third = maker_letter(maker[4:0]);
				r.product_id = product;
				r.serial_id = serial;
				r.name_length = LEN_W'(kept_len);
				r.last_of_run = (kept_len == 0);
				pending.push_back(r);
				for (i = 0; i < kept_len; i++) begin
					r = '0;
					r.is_name_char = 1'b1;
					r.name_char = text[i];
					r.last_of_run = (i == kept_len - 1);
					pending.push_back(r);
				end
				full_blocks++;
				if (kept_len > 0) named_blocks++;
				results_due += kept_len + 1;
			end
			clear_block();
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$error("%s: expected %0h, got %0h", field, want, got);
			end
		endfunction

		function void check_result(edid_result_t got);
			edid_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$error("result beat with nothing expected: %h", got);
				return;
			end
			want = pending.pop_front();
			results_ok++;
			compare("status", want.status, got.status);
			compare("letter_first", want.letter_first, got.letter_first);
			compare("letter_second", want.letter_second, got.letter_second);
			compare("letter_third", want.letter_third, got.letter_third);
			compare("product_id", want.product_id, got.product_id);
			compare("serial_id", want.serial_id, got.serial_id);
			compare("name_length", want.name_length, got.name_length);
			compare("is_name_char", want.is_name_char, got.is_name_char);
			compare("name_char", want.name_char, got.name_char);
			compare("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic                end_of_block = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                status;
	logic [LETTER_W-1:0] letter_first;
	logic [LETTER_W-1:0] letter_second;
	logic [LETTER_W-1:0] letter_third;
	logic [15:0]         product_id;
	logic [31:0]         serial_id;
	logic [LEN_W-1:0]    name_length;
	logic                is_name_char;
	logic [BYTE_W-1:0]   name_char;
	logic                last_of_run;

	bit                calm = 0;
	int                stall_left = 0;
	int                cycles = 0;
	edid_scoreboard    sb;
	logic [BYTE_W-1:0] block_buf [EDID_BYTES + TAIL_MAX];
	int                block_len;

	edid_base_block_parser_core dut (.*);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// check the result beat taken at this edge, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result({status, letter_first, letter_second, letter_third, product_id,
				serial_id, name_length, is_name_char, name_char, last_of_run});
		end
		if (calm) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, BURST_MAX - 1);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob);
		if (!calm && $urandom_range(0, 15) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_block <= eob;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b, eob);
	endtask

	task automatic send_block();
		int i;
		for (i = 0; i < block_len; i++) begin
			send_byte(block_buf[i], i == block_len - 1);
		end
	endtask

	function automatic logic [BYTE_W-1:0] trim_byte();
		case ($urandom_range(0, 2))
			0: return CHAR_LF;
			1: return CHAR_CR;
			default: return CHAR_SP;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] name_byte();
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(1, 255));
			1: return trim_byte();
			default: return 8'($urandom_range(8'h21, 8'h7E));
		endcase
	endfunction

	function automatic void put_desc(int slot, desc_kind_e kind, int name_len, tail_kind_e tail);
		int base;
		int j;
		base = DESC_FIRST + slot * DESC_STRIDE;
		if (kind == DESC_NOISE) return;
		block_buf[base] = CHAR_NUL;
		block_buf[base + 1] = CHAR_NUL;
		block_buf[base + 2] = CHAR_NUL;
		block_buf[base + 3] = TAG_NAME;
		if (kind == DESC_NEAR_MISS) begin
			j = $urandom_range(0, 3);
			block_buf[base + j] = (j == 3) ? 8'($urandom_range(0, 8'hFB)) :
				8'($urandom_range(1, 255));
		end else if (kind == DESC_OTHER_TAG) begin
			block_buf[base + 3] = 8'($urandom_range(8'hFD, 8'hFF));
		end
		// leave the byte ahead of the text random; the parser skips it
		for (j = 0; j < TEXT_BYTES; j++) begin
			if (j < name_len) begin
				block_buf[base + TEXT_START + j] = name_byte();
			end else if (tail == TAIL_NUL) begin
				block_buf[base + TEXT_START + j] = (j == name_len) ? CHAR_NUL : 8'($urandom);
			end else if (tail == TAIL_LF_PAD) begin
				block_buf[base + TEXT_START + j] = (j == name_len) ? CHAR_LF : CHAR_SP;
			end else begin
				block_buf[base + TEXT_START + j] = trim_byte();
			end
		end
	endfunction

	function automatic void build_short(int len);
		int i;
		block_len = len;
		for (i = 0; i < len; i++) block_buf[i] = 8'($urandom);
	endfunction

	function automatic void build_full();
		int s;
		// run past the end of the block so the tail bytes get dropped
		block_len = EDID_BYTES + TAIL_MAX;
		for (s = 0; s < block_len; s++) block_buf[s] = 8'($urandom);
		// near miss first, then the name that counts, then a later name to skip
		put_desc(0, DESC_NEAR_MISS, TEXT_BYTES, TAIL_NUL);
		put_desc(1, DESC_NAME, $urandom_range(6, TEXT_BYTES), tail_kind_e'($urandom_range(0, 2)));
		put_desc(2, DESC_NAME, 3, TAIL_LF_PAD);
		put_desc(3, desc_kind_e'($urandom_range(0, 3)), $urandom_range(0, TEXT_BYTES),
			tail_kind_e'($urandom_range(0, 2)));
	endfunction

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		block_len = 1;
		block_buf[0] = 8'hFF;
		send_block();
		block_buf[0] = 8'h00;
		send_block();
		build_short(6);
		send_block();
		build_full();
		send_block();

		while (sb.bytes_in < TARGET_BYTES - CALM_BYTES) begin
			build_short($urandom_range(1, 16));
			send_block();
		end

		// run the last blocks back to back on both sides
		calm = 1;
		while (sb.bytes_in < TARGET_BYTES) begin
			build_short($urandom_range(1, 4));
			send_block();
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d full and %0d short blocks, %0d of them with a monitor name",
			sb.full_blocks, sb.short_blocks, sb.named_blocks);
		$display("%0d bytes sent, %0d result beats checked", sb.bytes_in, sb.results_ok);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
